// ===== hw/rtl/rlpd_pkg.sv =====
// package with header byte class limits and result type for the rlp length prefix decoder
`default_nettype none

package rlpd_pkg;

   localparam logic [7:0] SINGLE_MAX     = 8'h7f;
   localparam logic [7:0] SHORT_STR_BASE = 8'h80;
   localparam logic [7:0] SHORT_STR_MAX  = 8'hb7;
   localparam logic [7:0] LONG_STR_MAX   = 8'hbf;
   localparam logic [7:0] SHORT_LST_BASE = 8'hc0;
   localparam logic [7:0] SHORT_LST_MAX  = 8'hf7;
   localparam logic [7:0] LONG_STR_UNSUP = 8'hbb;
   localparam logic [7:0] LONG_LST_UNSUP = 8'hfb;

   localparam logic [2:0] MAX_LEN_BYTES  = 3'd4;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_UNSUP = 1'b1;

   typedef struct packed {
      logic [31:0] field_length;
      logic [3:0]  header_size;
      logic        is_list;
      logic        status;
   } rlpd_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rlp_length_prefix_decoder_unit.sv =====
// rlp length prefix decoder: one stream byte per transaction, one result per completed header
//
// input channel req_: one byte of the encoded stream and a restart flag per
// transaction; restart drops a partial header and takes the byte as a header.
// result channel rsp_: payload length, prefix size, list flag and status for
// each completed header; single byte and short headers complete on their own
// byte, long headers on their last length byte, and headers with more than
// four length bytes complete at once with status set and length zero.
// a result is registered and appears in the cycle after the transaction of its last byte.
// throughput: one byte per cycle while the receiver does not stall, set by the single
// output register; header decode and the length shift-accumulate are combinational.
// when the receiver stalls a waiting result, req_stall rises and no new byte
// is taken until that result moves; the result holds steady meanwhile.
// reset (synchronous, active high) empties the output register and returns
// the decoder to awaiting a header byte.
`default_nettype none

module rlp_length_prefix_decoder_unit
   import rlpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_restart,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_field_length,
   output      logic [3:0]  rsp_header_size,
   output      logic        rsp_is_list,
   output      logic        rsp_status
);

   logic [2:0]      bytes_left_ff, bytes_left_in;
   logic [31:0]     length_acc_ff, length_acc_in;
   logic            list_flag_ff, list_flag_in;
   logic [2:0]      prefix_size_ff, prefix_size_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rlpd_result_type rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            emit;
   rlpd_result_type result;
   logic [7:0]      lol_str;
   logic [7:0]      lol_lst;
   logic [31:0]     acc_shift;
   logic [2:0]      left_dec;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign lol_str   = req_data_byte - SHORT_STR_MAX;
   assign lol_lst   = req_data_byte - SHORT_LST_MAX;
   assign acc_shift = {length_acc_ff[23:0], req_data_byte};
   assign left_dec  = bytes_left_ff - 3'd1;

   always_comb begin
      bytes_left_in  = bytes_left_ff;
      length_acc_in  = length_acc_ff;
      list_flag_in   = list_flag_ff;
      prefix_size_in = prefix_size_ff;
      emit           = 1'b0;
      result         = '{field_length: 32'd0, header_size: 4'd0,
                         is_list: 1'b0, status: STATUS_OK};
      if (req_restart || bytes_left_ff == 3'd0) begin
         bytes_left_in = 3'd0;
         if (req_data_byte <= SINGLE_MAX) begin
            emit                = 1'b1;
            result.field_length = 32'd1;
         end else if (req_data_byte <= SHORT_STR_MAX) begin
            emit                = 1'b1;
            result.field_length = {24'd0, req_data_byte - SHORT_STR_BASE};
            result.header_size  = 4'd1;
         end else if (req_data_byte <= LONG_STR_MAX) begin
            if (req_data_byte > LONG_STR_UNSUP) begin
               emit               = 1'b1;
               result.header_size = lol_str[3:0] + 4'd1;
               result.status      = STATUS_UNSUP;
            end else begin
               bytes_left_in  = lol_str[2:0];
               length_acc_in  = 32'd0;
               list_flag_in   = 1'b0;
               prefix_size_in = lol_str[2:0] + 3'd1;
            end
         end else if (req_data_byte <= SHORT_LST_MAX) begin
            emit                = 1'b1;
            result.field_length = {24'd0, req_data_byte - SHORT_LST_BASE};
            result.header_size  = 4'd1;
            result.is_list      = 1'b1;
         end else begin
            if (req_data_byte > LONG_LST_UNSUP) begin
               emit               = 1'b1;
               result.header_size = lol_lst[3:0] + 4'd1;
               result.is_list     = 1'b1;
               result.status      = STATUS_UNSUP;
            end else begin
               bytes_left_in  = lol_lst[2:0];
               length_acc_in  = 32'd0;
               list_flag_in   = 1'b1;
               prefix_size_in = lol_lst[2:0] + 3'd1;
            end
         end
      end else begin
         length_acc_in = acc_shift;
         bytes_left_in = left_dec;
         if (left_dec == 3'd0) begin
            emit                = 1'b1;
            result.field_length = acc_shift;
            result.header_size  = {1'b0, prefix_size_ff};
            result.is_list      = list_flag_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= 3'd0;
         length_acc_ff  <= 32'd0;
         list_flag_ff   <= 1'b0;
         prefix_size_ff <= 3'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            bytes_left_ff  <= bytes_left_in;
            length_acc_ff  <= length_acc_in;
            list_flag_ff   <= list_flag_in;
            prefix_size_ff <= prefix_size_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_field_length = rsp_data_ff.field_length;
   assign rsp_header_size  = rsp_data_ff.header_size;
   assign rsp_is_list      = rsp_data_ff.is_list;
   assign rsp_status       = rsp_data_ff.status;

endmodule

`default_nettype wire

// ===== tb/rlp_length_prefix_decoder_unit_test.sv =====
// testbench for the rlp length prefix decoder unit: directed and random header streams
`default_nettype none

module rlp_length_prefix_decoder_unit_test
   import rlpd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 550;

   typedef enum int {
      HK_SINGLE,
      HK_SHORT_STR,
      HK_SHORT_LIST,
      HK_LONG_STR,
      HK_LONG_LIST,
      HK_UNSUPPORTED,
      HK_NOISE,
      HK_COUNT
   } header_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_field_length;
   logic [3:0]  rsp_header_size;
   logic        rsp_is_list;
   logic        rsp_status;

   // decoder state mirror
   logic [2:0]  len_bytes_left = '0;
   logic [31:0] len_accum = '0;
   logic        hdr_list = 1'b0;
   logic [3:0]  hdr_prefix = '0;

   rlpd_result_type pending_headers[$];

   int cycle_count = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int unsup_count = 0;
   int restart_count = 0;
   int burst_left = 0;
   bit sender_gaps = 1'b0;
   int stall_pct = 0;
   int stall_run = 0;

   rlp_length_prefix_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_field_length (rsp_field_length),
      .rsp_header_size  (rsp_header_size),
      .rsp_is_list      (rsp_is_list),
      .rsp_status       (rsp_status)
   );

   always #5 clock = ~clock;

   function void push_header(input logic [31:0] len, input logic [3:0] size,
                             input logic lst, input logic st);
      rlpd_result_type r;
      r.field_length = len;
      r.header_size  = size;
      r.is_list      = lst;
      r.status       = st;
      pending_headers.push_back(r);
      if (st == STATUS_UNSUP) unsup_count++;
   endfunction

   function void begin_long_header(input int unsigned n, input logic lst);
      if (n > MAX_LEN_BYTES) begin
         len_bytes_left = '0;
         push_header(32'd0, 4'(1 + n), lst, STATUS_UNSUP);
      end else begin
         len_bytes_left = 3'(n);
         len_accum      = '0;
         hdr_list       = lst;
         hdr_prefix     = 4'(1 + n);
      end
   endfunction

   function void decode_header_byte(input logic [7:0] b, input logic rs);
      if (rs) restart_count++;
      if (rs || len_bytes_left == 0) begin
         len_bytes_left = '0;
         if (b <= SINGLE_MAX)
            push_header(32'd1, 4'd0, 1'b0, STATUS_OK);
         else if (b <= SHORT_STR_MAX)
            push_header(32'(b - SHORT_STR_BASE), 4'd1, 1'b0, STATUS_OK);
         else if (b <= LONG_STR_MAX)
            begin_long_header(int'(b - SHORT_STR_MAX), 1'b0);
         else if (b <= SHORT_LST_MAX)
            push_header(32'(b - SHORT_LST_BASE), 4'd1, 1'b1, STATUS_OK);
         else
            begin_long_header(int'(b - SHORT_LST_MAX), 1'b1);
      end else begin
         len_accum      = {len_accum[23:0], b};
         len_bytes_left = len_bytes_left - 3'd1;
         if (len_bytes_left == 0)
            push_header(len_accum, hdr_prefix, hdr_list, STATUS_OK);
      end
   endfunction

   function void check_result();
      rlpd_result_type want;
      results_seen++;
      if (pending_headers.size() == 0) begin
         if (error_count < 10)
            $display("unexpected result: len=%0d size=%0d list=%0b status=%0b",
                     rsp_field_length, rsp_header_size, rsp_is_list, rsp_status);
         error_count++;
         return;
      end
      want = pending_headers.pop_front();
      if (rsp_field_length !== want.field_length || rsp_header_size !== want.header_size ||
          rsp_is_list !== want.is_list || rsp_status !== want.status) begin
         if (error_count < 10) begin
            $write("mismatch at cycle %0d: expected len=%0d size=%0d list=%0b status=%0b",
                   cycle_count, want.field_length, want.header_size, want.is_list,
                   want.status);
            $display(", got len=%0d size=%0d list=%0b status=%0b",
                     rsp_field_length, rsp_header_size, rsp_is_list, rsp_status);
         end
         error_count++;
      end
   endfunction

   // transaction monitor and result checker
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall) decode_header_byte(req_data_byte, req_restart);
         if (rsp_valid && !rsp_stall) check_result();
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_run > 0) begin
         stall_run--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_run = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic rs);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = sender_gaps ? $urandom_range(0, 5) : 0;
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_restart   <= rs;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic test_single_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(SINGLE_MAX, 1'b0);
   endtask

   task automatic test_short_headers();
      send_byte(SHORT_STR_BASE, 1'b0);
      send_byte(SHORT_STR_MAX, 1'b0);
      send_byte(SHORT_LST_BASE, 1'b0);
      send_byte(SHORT_LST_MAX, 1'b0);
   endtask

   task automatic test_long_headers();
      send_byte(SHORT_STR_MAX + 8'd1, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(LONG_LST_UNSUP, 1'b0);
      repeat (4) send_byte(8'hff, 1'b0);
      // leading zero length byte
      send_byte(SHORT_LST_MAX + 8'd2, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h07, 1'b0);
   endtask

   task automatic test_unsupported_headers();
      send_byte(LONG_STR_UNSUP + 8'd1, 1'b0);
      send_byte(8'hff, 1'b0);
   endtask

   task automatic test_restart_mid_header();
      send_byte(SHORT_STR_MAX + 8'd3, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h05, 1'b1);
      send_byte(SHORT_LST_MAX + 8'd3, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(LONG_LST_UNSUP + 8'd1, 1'b1);
   endtask

   function automatic logic [7:0] pick_length_byte();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_random_header();
      header_kind_type kind;
      int unsigned n;
      logic rs;
      kind = header_kind_type'($urandom_range(0, int'(HK_COUNT) - 1));
      rs = ($urandom_range(0, 5) == 0);
      n = $urandom_range(1, 4);
      case (kind)
         HK_SINGLE:      send_byte(8'($urandom_range(0, 127)), rs);
         HK_SHORT_STR:   send_byte(8'($urandom_range(8'h80, 8'hb7)), rs);
         HK_SHORT_LIST:  send_byte(8'($urandom_range(8'hc0, 8'hf7)), rs);
         HK_UNSUPPORTED: send_byte($urandom_range(0, 1) ? 8'($urandom_range(8'hbc, 8'hbf))
                                                       : 8'($urandom_range(8'hfc, 8'hff)), rs);
         HK_NOISE:       send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         default: begin
            send_byte((kind == HK_LONG_LIST ? SHORT_LST_MAX : SHORT_STR_MAX) + 8'(n), rs);
            for (int i = 0; i < n; i++) begin
               // broken header: restart while length bytes are still owed
               if ($urandom_range(0, 14) == 0) begin
                  send_byte(8'($urandom_range(0, 255)), 1'b1);
                  return;
               end
               send_byte(pick_length_byte(), 1'b0);
            end
         end
      endcase
   endtask

   task automatic test_random_headers(input int count, input bit gaps, input int pct);
      int stop_at;
      sender_gaps = gaps;
      stall_pct   = pct;
      stop_at     = bytes_sent + count;
      while (bytes_sent < stop_at) send_random_header();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_bytes();
      test_short_headers();
      test_long_headers();
      test_unsupported_headers();
      test_restart_mid_header();
      test_random_headers(150, 1'b0, 0);
      test_random_headers(190, 1'b1, 60);
      test_random_headers(ITEM_TARGET - bytes_sent, 1'b1, 25);

      @(negedge clock);
      req_valid <= 1'b0;
      stall_pct = 20;
      while (pending_headers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (pending_headers.size() != 0) error_count++;
      $display("sent %0d stream bytes, %0d with restart; checked %0d header results",
               bytes_sent, restart_count, results_seen);
      $display("%0d unsupported long headers, %0d mismatches", unsup_count, error_count);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
